FILE: hw/rtl/grrlpe_pkg.sv
`default_nettype none

package grrlpe_pkg;

    // field widths fixed by the interface
    localparam int CODE_W = 12;
    localparam int RUN_W  = 20;
    localparam int COL_W  = 24;
    localparam int GRAY_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH        = 2'd0,
        CFG_TRANSPARENT_GRAY = 2'd1
    } t_cfg_reg;

    localparam logic [CODE_W-1:0] CODE_TRANSPARENT = 12'hFFF;
    localparam logic [RUN_W-1:0]  RUN_MAX          = 20'hFFFFF;
    localparam logic [COL_W-1:0]  ROW_WIDTH_RESET  = 24'd1;
    localparam logic [GRAY_W-1:0] TRANSPARENT_RESET = 8'hFF;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [CODE_W-1:0] color_code;
        logic [RUN_W-1:0]  run_length;
        logic              new_palette_entry;
        logic              end_of_row;
        logic              last_result;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/gray_row_run_length_palette_encoder.sv
`default_nettype none

// Gray row run-length encoder with a first-seen palette. One PIXEL_BITS gray
// pixel is taken per transfer in raster order and runs of equal pixels within
// a row come out as results carrying a 12-bit colour code (palette index in
// order of first emission, or 0xFFF for the transparent gray or a full
// palette), the run length (up to 2^20-1, longer runs are split), a flag for
// a freshly made palette entry, a row-end flag and a flag on the last result
// caused by a pixel. A pixel with first_of_image set clears the palette and
// the column position and drops any run still open. Throughput is one pixel
// per clock unless o_stall is raised: each pixel is handled by single-pass
// logic between the input register and a four-entry result queue. A pixel
// that closes two runs produces two results, which the queue drains one per
// cycle while i_stall is low, so a stream rich in such pixels is slowed by
// the single output port. The palette index store has one write port; a
// pixel that adds two palette entries while a previous write is still
// pending waits until that write has drained. The index store needs no
// clearing pass: per-value seen flags in flip-flops, cleared by reset and by
// first_of_image, mark which entries are meaningful. Row width 0 is taken as
// 2^24 pixels per row. Configuration writes are always ready and should only
// be issued while the block is idle.
module gray_row_run_length_palette_encoder
    import grrlpe_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int PIXEL_BITS      = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel input channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIXEL_BITS-1:0] i_pixel_value,
    input  wire logic                  i_first_of_image,
    // result output channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [CODE_W-1:0]          o_color_code,
    output logic [RUN_W-1:0]           o_run_length,
    output logic                       o_new_palette_entry,
    output logic                       o_end_of_row,
    output logic                       o_last_result,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NVALUES = 1 << PIXEL_BITS;
    localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
    localparam int PC_W    = $clog2(PALETTE_ENTRIES + 1);
    localparam int CMP_W   = (PIXEL_BITS > GRAY_W) ? PIXEL_BITS : GRAY_W;
    localparam logic [PC_W-1:0] PC_LIMIT = PC_W'(PALETTE_ENTRIES);

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [COL_W-1:0]  r_row_width;
    logic [GRAY_W-1:0] r_tgray;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
            r_tgray     <= TRANSPARENT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // indices beyond the register list are ignored
            if (i_cfg_index == CFG_ROW_WIDTH) begin
                r_row_width <= i_cfg_data[COL_W-1:0];
            end
            if (i_cfg_index == CFG_TRANSPARENT_GRAY) begin
                r_tgray <= i_cfg_data[GRAY_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------------
    // state
    // ---------------------------------------------------------------------
    // input register
    logic                  r_in_valid;
    logic [PIXEL_BITS-1:0] r_pix;
    logic                  r_first;

    // run and row tracking
    logic [PIXEL_BITS-1:0] r_run_value, n_run_value;
    logic [RUN_W-1:0]      r_run_count, n_run_count;
    logic [COL_W-1:0]      r_col, n_col;
    logic [IDX_W-1:0]      r_run_idx, n_run_idx;  // palette index of r_run_value once seen

    // palette
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [NVALUES-1:0]    r_seen, n_seen;
    logic [IDX_W-1:0]      r_index_mem [NVALUES];

    // palette index lookup of the accepted pixel, with bypass of fresh writes
    logic [IDX_W-1:0]      r_mem_q;
    logic                  r_byp_hit;
    logic [IDX_W-1:0]      r_byp_data;

    // deferred palette write when one pixel makes two entries
    logic                  r_pend_valid, n_pend_valid;
    logic [PIXEL_BITS-1:0] r_pend_addr, n_pend_addr;
    logic [IDX_W-1:0]      r_pend_data, n_pend_data;

    // result queue
    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_head, r_tail;
    logic [FIFO_CNT_W-1:0] r_count;

    // ---------------------------------------------------------------------
    // single-pass run logic
    // ---------------------------------------------------------------------
    logic                  fire;
    logic                  in_accept;
    logic                  pop;

    logic [NVALUES-1:0]    seen_eff;
    logic [PC_W-1:0]       pc_eff;
    logic [COL_W-1:0]      col_eff;
    logic [RUN_W-1:0]      cnt_eff;
    logic [COL_W:0]        width_ext;
    logic [COL_W:0]        next_col;
    logic                  row_end;
    logic                  use_new;
    logic [PIXEL_BITS-1:0] val_new;
    logic [RUN_W-1:0]      cnt_new;
    logic [IDX_W-1:0]      idx_pix;

    logic                  emit1, emit2;
    logic                  transp1, transp2;
    logic                  seen1, seen2;
    logic                  alloc1, alloc2;
    logic [PC_W-1:0]       pc1;
    logic [IDX_W-1:0]      idx2;
    t_result               res1, res2;

    always_comb begin
        // first_of_image wipes palette, column and open run before the pixel
        seen_eff = r_first ? '0 : r_seen;
        pc_eff   = r_first ? '0 : r_pc;
        col_eff  = r_first ? '0 : r_col;
        cnt_eff  = r_first ? '0 : r_run_count;

        // zero row width stands for 2^24
        width_ext = (r_row_width == '0) ? {1'b1, {COL_W{1'b0}}} : {1'b0, r_row_width};
        next_col  = {1'b0, col_eff} + {{COL_W{1'b0}}, 1'b1};
        row_end   = next_col >= width_ext;

        // previous run closes on a different pixel mid-row
        emit1   = (col_eff != '0) && (r_pix != r_run_value) && (cnt_eff != '0);
        use_new = (col_eff == '0) || (r_pix != r_run_value);
        val_new = r_pix;
        cnt_new = use_new ? {{(RUN_W-1){1'b0}}, 1'b1} : cnt_eff + {{(RUN_W-1){1'b0}}, 1'b1};
        // current run closes at row end or on reaching the longest run
        emit2   = (cnt_new == RUN_MAX) || row_end;

        // colour code of the closing run
        transp1 = CMP_W'(r_run_value) == CMP_W'(r_tgray);
        seen1   = seen_eff[r_run_value];
        alloc1  = emit1 && !transp1 && !seen1 && (pc_eff < PC_LIMIT);
        pc1     = pc_eff + PC_W'(alloc1);

        // colour code of the current run, after any entry made for the first
        idx_pix = r_byp_hit ? r_byp_data : r_mem_q;
        idx2    = use_new ? idx_pix : r_run_idx;
        transp2 = CMP_W'(val_new) == CMP_W'(r_tgray);
        seen2   = seen_eff[val_new];
        alloc2  = emit2 && !transp2 && !seen2 && (pc1 < PC_LIMIT);

        res1.color_code        = transp1 ? CODE_TRANSPARENT :
                                 seen1   ? CODE_W'(r_run_idx) :
                                 alloc1  ? CODE_W'(pc_eff) : CODE_TRANSPARENT;
        res1.run_length        = cnt_eff;
        res1.new_palette_entry = alloc1;
        res1.end_of_row        = 1'b0;
        res1.last_result       = !emit2;

        res2.color_code        = transp2 ? CODE_TRANSPARENT :
                                 seen2   ? CODE_W'(idx2) :
                                 alloc2  ? CODE_W'(pc1) : CODE_TRANSPARENT;
        res2.run_length        = cnt_new;
        res2.new_palette_entry = alloc2;
        res2.end_of_row        = row_end;
        res2.last_result       = 1'b1;
    end

    // a pixel goes when the queue has room for two results and the index
    // store can absorb its writes
    assign fire = r_in_valid
                  && (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2))
                  && !(r_pend_valid && alloc1 && alloc2);

    assign o_stall   = r_in_valid && !fire;
    assign in_accept = i_valid && !o_stall;

    // next state of run, row and palette
    always_comb begin
        n_run_value = r_run_value;
        n_run_count = r_run_count;
        n_col       = r_col;
        n_run_idx   = r_run_idx;
        n_pc        = r_pc;
        n_seen      = r_seen;
        if (fire) begin
            n_run_value = val_new;
            n_run_count = emit2 ? '0 : cnt_new;
            n_col       = row_end ? '0 : next_col[COL_W-1:0];
            n_pc        = pc1 + PC_W'(alloc2);
            n_seen      = seen_eff;
            if (alloc1) begin
                n_seen[r_run_value] = 1'b1;
            end
            if (alloc2) begin
                n_seen[val_new] = 1'b1;
                n_run_idx       = pc1[IDX_W-1:0];
            end else if (use_new) begin
                n_run_idx = idx_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_value <= '0;
            r_run_count <= '0;
            r_col       <= '0;
            r_pc        <= '0;
            r_seen      <= '0;
        end else begin
            r_run_value <= n_run_value;
            r_run_count <= n_run_count;
            r_col       <= n_col;
            r_pc        <= n_pc;
            r_seen      <= n_seen;
        end
    end

    // only meaningful while the seen flag of the run value is set
    always_ff @(posedge i_clk) begin
        r_run_idx <= n_run_idx;
    end

    // ---------------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix   <= i_pixel_value;
            r_first <= i_first_of_image;
        end
    end

    // ---------------------------------------------------------------------
    // palette index store: one write, one registered read per cycle
    // ---------------------------------------------------------------------
    logic                  wr_en;
    logic [PIXEL_BITS-1:0] wr_addr;
    logic [IDX_W-1:0]      wr_data;

    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = r_pend_addr;
        wr_data      = r_pend_data;
        n_pend_valid = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_pend_data  = r_pend_data;
        if (r_pend_valid) begin
            // drain the held write, park at most one new entry
            wr_en = 1'b1;
            if (fire && alloc1) begin
                n_pend_valid = 1'b1;
                n_pend_addr  = r_run_value;
                n_pend_data  = pc_eff[IDX_W-1:0];
            end else if (fire && alloc2) begin
                n_pend_valid = 1'b1;
                n_pend_addr  = val_new;
                n_pend_data  = pc1[IDX_W-1:0];
            end
        end else if (fire && alloc2) begin
            wr_en   = 1'b1;
            wr_addr = val_new;
            wr_data = pc1[IDX_W-1:0];
            if (alloc1) begin
                n_pend_valid = 1'b1;
                n_pend_addr  = r_run_value;
                n_pend_data  = pc_eff[IDX_W-1:0];
            end
        end else if (fire && alloc1) begin
            wr_en   = 1'b1;
            wr_addr = r_run_value;
            wr_data = pc_eff[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_index_mem[wr_addr] <= wr_data;
        end
        if (in_accept) begin
            r_mem_q <= r_index_mem[i_pixel_value];
        end
    end

    // the newest write wins: parked entry, then the one going in now
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (n_pend_valid && (n_pend_addr == i_pixel_value)) begin
                r_byp_hit  <= 1'b1;
                r_byp_data <= n_pend_data;
            end else if (wr_en && (wr_addr == i_pixel_value)) begin
                r_byp_hit  <= 1'b1;
                r_byp_data <= wr_data;
            end else begin
                r_byp_hit  <= 1'b0;
                r_byp_data <= wr_data;
            end
        end
    end

    // ---------------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------------
    logic [1:0]            push_n;
    logic [FIFO_PTR_W-1:0] tail_p1;

    assign push_n  = fire ? ({1'b0, emit1} + {1'b0, emit2}) : 2'd0;
    assign tail_p1 = r_tail + {{(FIFO_PTR_W-1){1'b0}}, 1'b1};
    assign pop     = (r_count != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (emit1) begin
                r_fifo[r_tail] <= res1;
                if (emit2) begin
                    r_fifo[tail_p1] <= res2;
                end
            end else if (emit2) begin
                r_fifo[r_tail] <= res2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + FIFO_PTR_W'(push_n);
            r_head  <= r_head + FIFO_PTR_W'(pop);
            r_count <= r_count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
        end
    end

    assign o_valid             = r_count != '0;
    assign o_color_code        = r_fifo[r_head].color_code;
    assign o_run_length        = r_fifo[r_head].run_length;
    assign o_new_palette_entry = r_fifo[r_head].new_palette_entry;
    assign o_end_of_row        = r_fifo[r_head].end_of_row;
    assign o_last_result       = r_fifo[r_head].last_result;

endmodule

`default_nettype wire
